### hdl/dss_pkg.sv
// shared types, codes and defaults for the dual stack shared memory block
`timescale 1ns / 1ps

package dss_pkg;

  localparam int DATA_W        = 32;
  localparam int CMD_W         = 3;
  localparam int STATUS_W      = 2;
  localparam int DEPTH_DEF     = 64;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_ONE = 3'd0,
    CMD_POP_ONE  = 3'd1,
    CMD_SHOW_ONE = 3'd2,
    CMD_PUSH_TWO = 3'd3,
    CMD_POP_TWO  = 3'd4,
    CMD_SHOW_TWO = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_SHOW
  } state_t;

endpackage

### hdl/dss_ram.sv
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module dss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/dual_stack_shared_memory_top.sv
// top level: two stacks sharing one word memory, with command sequencer
`timescale 1ns / 1ps

// usage
// - command channel: drive in_cmd / in_value with start; a transfer happens at
//   a rising edge where start is high and busy is low
// - result channel: each result sits on out_status / out_data / out_last for
//   exactly one cycle while out_valid is high; the receiver cannot stall, so
//   results must be taken as they come
// - stack one grows up from word 0, stack two down from word DEPTH-1
// - push and every full/empty error: one result, the cycle after the transfer;
//   the next command can follow in the very next cycle
// - pop: the word comes back through the ram's registered read port and then
//   the result register; busy holds for one cycle, so the next command waits
//   until the word has been read
// - show of a stack holding n words: n results on consecutive cycles, each
//   through the ram read register and the result register, last marked; busy
//   holds until the last word is read, as the single ram read port gives one word a cycle
// - command codes six and seven are dropped without a result
// - reset (rst_n low, synchronous) empties both stacks and clears the
//   sequencer; the ram contents are not cleared and need no clearing pass

module dual_stack_shared_memory_top
  import dss_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [CMD_W-1:0]           in_cmd,
  input  logic signed [DATA_W-1:0]   in_value,
  output logic                       out_valid,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [DATA_W-1:0]   out_data,
  output logic                       out_last
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // stack counts and sequencer
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    low_r, low_nxt;
  logic [CNT_W-1:0]    high_r, high_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;      // words of a show still to read
  logic [ADDR_W-1:0]   ptr_r, ptr_nxt;      // next show address
  logic                up_r, up_nxt;        // show walks upward (stack two)
  logic                pend_r, pend_nxt;    // ram read data arrives this cycle
  logic                pend_last_r, pend_last_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;
  logic                out_last_r, out_last_nxt;

  // ram ports
  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [ADDR_W-1:0]   raddr;
  logic [WORD_BITS-1:0] rdata;

  logic                accept;
  cmd_t                cmd;
  logic [CNT_W:0]      used;
  logic                full;
  logic [ADDR_W-1:0]   top_one;
  logic [ADDR_W-1:0]   top_two;
  logic [ADDR_W-1:0]   next_two;
  logic [DATA_W-1:0]   push_ext;
  logic [DATA_W-1:0]   rd_ext;

  assign busy   = (state_r != ST_IDLE) || pend_r;
  assign accept = start && !busy;
  assign cmd    = cmd_t'(in_cmd);

  assign used = {1'b0, low_r} + {1'b0, high_r};
  assign full = (used >= (CNT_W + 1)'(DEPTH));

  // top of stack one, top of stack two, and the slot a push two fills
  assign top_one  = ADDR_W'(low_r - CNT_W'(1));
  assign top_two  = ADDR_W'(CNT_W'(DEPTH) - high_r);
  assign next_two = ADDR_W'(CNT_W'(DEPTH - 1) - high_r);

  // stored words keep the low WORD_BITS bits of the pushed value
  assign wdata = WORD_BITS'($unsigned(in_value));

  // words read back or echoed are sign-extended from WORD_BITS and cut to 32
  generate
    if (WORD_BITS >= DATA_W) begin : g_wide
      assign push_ext = wdata[DATA_W-1:0];
      assign rd_ext   = rdata[DATA_W-1:0];
    end else begin : g_narrow
      assign push_ext = {{(DATA_W - WORD_BITS){wdata[WORD_BITS-1]}}, wdata};
      assign rd_ext   = {{(DATA_W - WORD_BITS){rdata[WORD_BITS-1]}}, rdata};
    end
  endgenerate

  dss_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // next state: a show of more than one word streams from ST_SHOW
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && cmd == CMD_SHOW_ONE && low_r > CNT_W'(1)) begin
          state_nxt = ST_SHOW;
        end else if (accept && cmd == CMD_SHOW_TWO && high_r > CNT_W'(1)) begin
          state_nxt = ST_SHOW;
        end
      end
      ST_SHOW: begin
        if (rem_r == CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath, ram control and result register
  always_comb begin
    low_nxt        = low_r;
    high_nxt       = high_r;
    rem_nxt        = rem_r;
    ptr_nxt        = ptr_r;
    up_nxt         = up_r;
    pend_nxt       = 1'b0;
    pend_last_nxt  = pend_last_r;
    we             = 1'b0;
    waddr          = low_r[ADDR_W-1:0];
    raddr          = ptr_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = STATUS_OK;
    out_data_nxt   = '0;
    out_last_nxt   = 1'b1;

    // word read last cycle goes into the result register now
    if (pend_r) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = STATUS_OK;
      out_data_nxt   = rd_ext;
      out_last_nxt   = pend_last_r;
    end

    if (state_r == ST_SHOW) begin
      raddr         = ptr_r;
      pend_nxt      = 1'b1;
      pend_last_nxt = (rem_r == CNT_W'(1));
      rem_nxt       = rem_r - CNT_W'(1);
      ptr_nxt       = up_r ? ptr_r + ADDR_W'(1) : ptr_r - ADDR_W'(1);
    end

    if (accept) begin
      case (cmd)
        CMD_PUSH_ONE, CMD_PUSH_TWO: begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (full) begin
            out_status_nxt = STATUS_FULL;
          end else begin
            we             = 1'b1;
            out_status_nxt = STATUS_OK;
            out_data_nxt   = push_ext;
            if (cmd == CMD_PUSH_ONE) begin
              waddr   = low_r[ADDR_W-1:0];
              low_nxt = low_r + CNT_W'(1);
            end else begin
              waddr    = next_two;
              high_nxt = high_r + CNT_W'(1);
            end
          end
        end
        CMD_POP_ONE: begin
          if (low_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_EMPTY;
          end else begin
            raddr         = top_one;
            pend_nxt      = 1'b1;
            pend_last_nxt = 1'b1;
            low_nxt       = low_r - CNT_W'(1);
          end
        end
        CMD_POP_TWO: begin
          if (high_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_EMPTY;
          end else begin
            raddr         = top_two;
            pend_nxt      = 1'b1;
            pend_last_nxt = 1'b1;
            high_nxt      = high_r - CNT_W'(1);
          end
        end
        CMD_SHOW_ONE: begin
          if (low_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_EMPTY;
          end else begin
            raddr         = top_one;
            pend_nxt      = 1'b1;
            pend_last_nxt = (low_r == CNT_W'(1));
            rem_nxt       = low_r - CNT_W'(1);
            ptr_nxt       = top_one - ADDR_W'(1);
            up_nxt        = 1'b0;
          end
        end
        CMD_SHOW_TWO: begin
          if (high_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_EMPTY;
          end else begin
            raddr         = top_two;
            pend_nxt      = 1'b1;
            pend_last_nxt = (high_r == CNT_W'(1));
            rem_nxt       = high_r - CNT_W'(1);
            ptr_nxt       = top_two + ADDR_W'(1);
            up_nxt        = 1'b1;
          end
        end
        default: begin
          // unused codes: no result, no change
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      low_r       <= '0;
      high_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    rem_r        <= rem_nxt;
    ptr_r        <= ptr_nxt;
    up_r         <= up_nxt;
    pend_last_r  <= pend_last_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

`ifndef SYNTHESIS
  // the two stacks never overlap
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    used <= (CNT_W + 1)'(DEPTH))
    else $error("stack counts exceed memory depth");

  // a ram write only comes from an accepted push
  a_write_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> accept && (cmd == CMD_PUSH_ONE || cmd == CMD_PUSH_TWO))
    else $error("ram write without accepted push");

  // every pending read turns into a result the next cycle
  a_read_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> out_valid_r && out_status_r == STATUS_OK)
    else $error("pending read produced no result");

  // counts only move on an accepted command
  a_counts_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(low_r) && $stable(high_r))
    else $error("stack count changed without a command");
`endif

endmodule
